[hw/rtl/cc20_pkg.sv]
// cc20_pkg: shared types, constants and helper functions for the chacha20 unit
// used by cc20_core and chacha20_stream_cipher_unit, no dependencies
package cc20_pkg;

  // chacha constant words ("expand 32-byte k")
  localparam logic [31:0] SIGMA_0 = 32'h61707865;
  localparam logic [31:0] SIGMA_1 = 32'h3320646e;
  localparam logic [31:0] SIGMA_2 = 32'h79622d32;
  localparam logic [31:0] SIGMA_3 = 32'h6b206574;

  localparam int DOUBLE_ROUNDS = 10;
  // each double round is a column and a diagonal round, each of two half steps
  localparam int ROUND_STEPS = DOUBLE_ROUNDS * 4;
  localparam logic [5:0] STEP_FF = 6'(ROUND_STEPS);
  localparam logic [5:0] STEP_DONE = 6'(ROUND_STEPS + 1);

  // configuration register indexes
  localparam logic [2:0] REG_KEY_0 = 3'd0;
  localparam logic [2:0] REG_KEY_1 = 3'd1;
  localparam logic [2:0] REG_KEY_2 = 3'd2;
  localparam logic [2:0] REG_KEY_3 = 3'd3;
  localparam logic [2:0] REG_NONCE_LOW = 3'd4;
  localparam logic [2:0] REG_NONCE_HIGH = 3'd5;
  localparam logic [2:0] REG_START_CTR = 3'd6;

  typedef struct packed {
    logic [63:0] text_word;
    logic [3:0]  valid_bytes;
    logic        first;
    logic        last;
  } in_t;

  typedef struct packed {
    logic [63:0] result_word;
    logic [3:0]  result_bytes;
    logic        result_last;
  } out_t;

  typedef logic [15:0][31:0] word_arr_t;
  typedef logic [7:0][63:0] ks_block_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } qr_t;

  // one half of a quarter round: rotations 16/12, or 8/7 for the second half
  function automatic qr_t qr_half(qr_t q, logic second);
    qr_t r;
    logic [31:0] dx;
    logic [31:0] bx;
    r.a = q.a + q.b;
    dx = q.d ^ r.a;
    r.d = second ? {dx[23:0], dx[31:24]} : {dx[15:0], dx[31:16]};
    r.c = q.c + r.d;
    bx = q.b ^ r.c;
    r.b = second ? {bx[24:0], bx[31:25]} : {bx[19:0], bx[31:20]};
    return r;
  endfunction

  // xor with keystream, zero the bytes beyond the valid count
  function automatic logic [63:0] apply_ks(logic [63:0] text, logic [63:0] ks,
                                           logic [3:0] nbytes);
    logic [63:0] r;
    r = text ^ ks;
    for (int i = 0; i < 8; i++) begin
      if (nbytes <= 4'(i)) begin
        r[8*i +: 8] = 8'h00;
      end
    end
    return r;
  endfunction

endpackage

[hw/rtl/cc20_core.sv]
// cc20_core: iterative chacha20 block function, four quarter-round lanes
// doing one half quarter round per cycle; depends on cc20_pkg
module cc20_core import cc20_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  word_arr_t init_words,
  output logic      done,
  output ks_block_t ks
);

  word_arr_t w;
  word_arr_t init_reg;
  word_arr_t w_round;
  word_arr_t w_ff;
  logic      busy;
  logic [5:0] step;

  // four lanes, column or diagonal indexing
  always_comb begin
    logic [1:0] ln;
    logic [1:0] bo;
    logic [1:0] co;
    logic [1:0] dof;
    logic [3:0] ia;
    logic [3:0] ib;
    logic [3:0] ic;
    logic [3:0] id;
    qr_t q;
    w_round = w;
    for (int j = 0; j < 4; j++) begin
      ln = 2'(j);
      bo = step[1] ? 2'd1 : 2'd0;
      co = step[1] ? 2'd2 : 2'd0;
      dof = step[1] ? 2'd3 : 2'd0;
      ia = {2'd0, ln};
      ib = {2'd1, 2'(ln + bo)};
      ic = {2'd2, 2'(ln + co)};
      id = {2'd3, 2'(ln + dof)};
      q = qr_half({w[ia], w[ib], w[ic], w[id]}, step[0]);
      w_round[ia] = q.a;
      w_round[ib] = q.b;
      w_round[ic] = q.c;
      w_round[id] = q.d;
    end
  end

  // feed-forward
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      w_ff[i] = w[i] + init_reg[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      if (step == STEP_DONE) begin
        busy <= 1'b0;
      end else begin
        step <= step + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      w <= init_words;
      init_reg <= init_words;
    end else if (busy && step < STEP_FF) begin
      w <= w_round;
    end else if (busy && step == STEP_FF) begin
      w <= w_ff;
    end
  end

  assign done = busy && (step == STEP_DONE);

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      ks[k] = {w[2*k+1], w[2*k]};
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("block started while busy");
  a_done_ends: assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("busy after done");
  a_rose_step: assert property (@(posedge clk) disable iff (rst) $rose(busy) |-> step == '0)
    else $error("step not cleared at block start");

endmodule

[hw/rtl/chacha20_stream_cipher_unit.sv]
// chacha20_stream_cipher_unit: top level, config registers, keystream store and
// result register; depends on cc20_pkg and cc20_core
// an item that opens a keystream block gives its result once the block is made
//   (40 round steps, one feed-forward step, one load); other items in the next cycle
// one round unit serves up to eight items per block; no beat is taken while it runs
// reset: synchronous, clears registers, block counter and word position; the
//   keystream store is not cleared, a block is always made before it is read
module chacha20_stream_cipher_unit import cc20_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         item,
  output logic        result_valid,
  input  logic        result_ready,
  output out_t        result,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_GEN = 1'b1;

  // configuration registers
  logic [63:0] key_part [4];
  logic [63:0] nonce_low;
  logic [31:0] nonce_high;
  logic [31:0] start_counter;

  // sequencing state
  logic        state;
  logic [2:0]  word_position;
  logic [31:0] block_counter;
  logic [63:0] ks_words [8];
  in_t         hold;

  // accept-side decode
  logic        accept;
  logic        need_blk;
  logic        core_start;
  logic [31:0] sel_ctr;
  logic [2:0]  sel_pos;
  word_arr_t   init_words;

  // round unit
  logic        blk_done;
  ks_block_t   blk_ks;

  // a first beat restarts at the configured counter and word zero
  assign sel_ctr = item.first ? start_counter : block_counter;
  assign sel_pos = item.first ? 3'd0 : word_position;
  assign need_blk = (sel_pos == 3'd0);

  // take a beat when idle and the result register is free or draining
  assign in_ready = !rst && (state == S_IDLE) && (!result_valid || result_ready);
  assign accept = in_valid && in_ready;
  assign core_start = accept && need_blk;

  // initial block state
  always_comb begin
    init_words[0] = SIGMA_0;
    init_words[1] = SIGMA_1;
    init_words[2] = SIGMA_2;
    init_words[3] = SIGMA_3;
    for (int i = 0; i < 4; i++) begin
      init_words[4 + 2*i] = key_part[i][31:0];
      init_words[5 + 2*i] = key_part[i][63:32];
    end
    init_words[12] = sel_ctr;
    init_words[13] = nonce_low[31:0];
    init_words[14] = nonce_low[63:32];
    init_words[15] = nonce_high;
  end

  cc20_core u_core (
    .clk        (clk),
    .rst        (rst),
    .start      (core_start),
    .init_words (init_words),
    .done       (blk_done),
    .ks         (blk_ks)
  );

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      result_valid <= 1'b0;
      word_position <= '0;
      block_counter <= '0;
      for (int i = 0; i < 4; i++) begin
        key_part[i] <= '0;
      end
      nonce_low <= '0;
      nonce_high <= '0;
      start_counter <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_KEY_0:      key_part[0] <= cfg_data;
          REG_KEY_1:      key_part[1] <= cfg_data;
          REG_KEY_2:      key_part[2] <= cfg_data;
          REG_KEY_3:      key_part[3] <= cfg_data;
          REG_NONCE_LOW:  nonce_low <= cfg_data;
          REG_NONCE_HIGH: nonce_high <= cfg_data[31:0];
          REG_START_CTR:  start_counter <= cfg_data[31:0];
          default: begin
          end
        endcase
      end

      // result register valid
      if ((accept && !need_blk) || (state == S_GEN && blk_done)) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (core_start) begin
            state <= S_GEN;
          end
        end
        S_GEN: begin
          if (blk_done) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      if (accept) begin
        word_position <= sel_pos + 3'd1;
        if (need_blk) begin
          block_counter <= sel_ctr + 32'd1;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      hold <= item;
    end
    if (accept && !need_blk) begin
      result.result_word <= apply_ks(item.text_word, ks_words[word_position],
                                     item.valid_bytes);
      result.result_bytes <= item.valid_bytes;
      result.result_last <= item.last;
    end else if (state == S_GEN && blk_done) begin
      result.result_word <= apply_ks(hold.text_word, blk_ks[0], hold.valid_bytes);
      result.result_bytes <= hold.valid_bytes;
      result.result_last <= hold.last;
    end
    if (blk_done) begin
      for (int k = 0; k < 8; k++) begin
        ks_words[k] <= blk_ks[k];
      end
    end
  end

  a_done_free: assert property (@(posedge clk) disable iff (rst)
    blk_done |-> (state == S_GEN) && !result_valid)
    else $error("block finished with result register occupied");
  a_fast_result: assert property (@(posedge clk) disable iff (rst)
    accept && !need_blk |=> result_valid)
    else $error("no result after keystream hit");
  a_pos_after_blk: assert property (@(posedge clk) disable iff (rst)
    core_start |=> word_position == 3'd1)
    else $error("word position wrong after block start");
  a_zero_bytes: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.result_bytes == 4'd0 |-> result.result_word == 64'd0)
    else $error("nonzero result word with zero bytes");

endmodule
